>>> sv/fvd_pkg.sv
// ----------------------------------------------------------------------------
// fvd_pkg
// Shared types and constants for the fan triangulation / vertex dedup block.
// ----------------------------------------------------------------------------
package fvd_pkg;

	localparam int VNUM_W = 10;

	localparam logic CFG_USE_TEX = 1'b0;
	localparam logic CFG_USE_NRM = 1'b1;

	typedef struct packed {
		logic first_use;
		logic table_full;
	} lk_flags_t;

endpackage

>>> sv/fvd_ram.sv
// ----------------------------------------------------------------------------
// fvd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fvd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/fvd_lookup.sv
// ----------------------------------------------------------------------------
// fvd_lookup
// Hash table lookup/insert engine with linear probing, vertex numbering and
// a clearing pass over the slot memory.
// ----------------------------------------------------------------------------
module fvd_lookup #(
	parameter int MAX_VERTICES = 1024,
	parameter int TABLE_SLOTS  = 2048,
	parameter int INDEX_BITS   = 24,
	localparam int KW    = 3 * INDEX_BITS + 2,
	localparam int LIMIT = (MAX_VERTICES < TABLE_SLOTS) ? MAX_VERTICES : TABLE_SLOTS,
	localparam int NB    = $clog2(LIMIT + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr_start,
	input  logic                start,
	input  logic [KW-1:0]       key,
	input  logic                res_take,
	output logic                res_valid,
	output logic [NB-1:0]       res_number,
	output fvd_pkg::lk_flags_t  res_flags,
	output logic                busy
);

	import fvd_pkg::*;

	localparam int SB  = $clog2(TABLE_SLOTS);
	localparam int EW  = 1 + NB + KW;
	localparam int PCW = $clog2(TABLE_SLOTS + 1);

	localparam logic [1:0] L_IDLE = 2'd0;
	localparam logic [1:0] L_CLR  = 2'd1;
	localparam logic [1:0] L_CMP  = 2'd2;

	logic [1:0]     st_q;
	logic [SB-1:0]  addr_q;
	logic [PCW-1:0] probe_q;
	logic [NB-1:0]  next_q;
	logic [KW-1:0]  key_q;

	logic           ram_we;
	logic [EW-1:0]  ram_wdata;
	logic           ram_re;
	logic [SB-1:0]  ram_raddr;
	logic [EW-1:0]  ram_rdata;

	logic           ent_valid;
	logic [NB-1:0]  ent_num;
	logic [KW-1:0]  ent_key;
	logic           hit;
	logic           miss;
	logic           room;
	logic           insert;
	logic [SB-1:0]  addr_inc;
	logic [SB-1:0]  key_hash;

	function automatic logic [SB-1:0] slot_hash(input logic [KW-1:0] k);
		logic [SB-1:0] h;
		h = '0;
		for (int i = 0; i < KW; i++) begin
			h[i % SB] = h[i % SB] ^ k[i];
		end
		if ({1'b0, h} >= (SB + 1)'(TABLE_SLOTS)) begin
			h = SB'({1'b0, h} - (SB + 1)'(TABLE_SLOTS));
		end
		return h;
	endfunction

	assign key_hash  = slot_hash(key);
	assign ent_valid = ram_rdata[EW-1];
	assign ent_num   = ram_rdata[KW +: NB];
	assign ent_key   = ram_rdata[KW-1:0];

	assign addr_inc  = (addr_q == SB'(TABLE_SLOTS - 1)) ? '0 : addr_q + 1'b1;
	assign hit       = ent_valid && (ent_key == key_q);
	assign miss      = !ent_valid || (probe_q == PCW'(TABLE_SLOTS));
	assign room      = next_q < NB'(LIMIT);
	assign res_valid = (st_q == L_CMP) && (hit || miss);
	assign insert    = res_valid && res_take && !hit && room;

	assign res_number           = hit ? ent_num : (room ? next_q : '0);
	assign res_flags.first_use  = !hit && room;
	assign res_flags.table_full = !hit && !room;
	assign busy                 = st_q != L_IDLE;

	assign ram_we    = (st_q == L_CLR) || insert;
	assign ram_wdata = (st_q == L_CLR) ? '0 : {1'b1, next_q, key_q};
	assign ram_re    = ((st_q == L_IDLE) && start && !clr_start) ||
	                   ((st_q == L_CMP) && !(hit || miss));
	assign ram_raddr = (st_q == L_IDLE) ? key_hash : addr_inc;

	fvd_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= L_CLR;
			addr_q  <= '0;
			probe_q <= '0;
			next_q  <= '0;
		end else begin
			case (st_q)
				L_IDLE: begin
					if (clr_start) begin
						st_q   <= L_CLR;
						addr_q <= '0;
						next_q <= '0;
					end else if (start) begin
						st_q    <= L_CMP;
						addr_q  <= key_hash;
						probe_q <= PCW'(1);
					end
				end
				L_CLR: begin
					if (addr_q == SB'(TABLE_SLOTS - 1)) begin
						st_q <= L_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				L_CMP: begin
					if (res_valid) begin
						if (res_take) begin
							st_q <= L_IDLE;
							if (insert) begin
								next_q <= next_q + 1'b1;
							end
						end
					end else begin
						addr_q  <= addr_inc;
						probe_q <= probe_q + 1'b1;
					end
				end
				default: begin
					st_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == L_IDLE) && start && !clr_start) begin
			key_q <= key;
		end
	end

endmodule

>>> sv/fan_triangulate_vertex_dedup_top.sv
// ----------------------------------------------------------------------------
// fan_triangulate_vertex_dedup_top
// Fan triangulation of polygon corners with vertex index deduplication.
// ----------------------------------------------------------------------------
// A corner that closes no triangle is only stored, with no table lookup. A corner from the
// third of a polygon on emits one triangle: three table lookups done one after
// another on the single slot memory, each probing slot after slot from the key's
// hash, and no corner is accepted until the last result is taken.
// The slot memory is swept clear after reset and on every corner flagged
// new_mesh; that pass visits all TABLE_SLOTS slots, and no corner is
// accepted during it.
module fan_triangulate_vertex_dedup_top #(
	parameter int MAX_VERTICES = 1024,
	parameter int TABLE_SLOTS  = 2048,
	parameter int INDEX_BITS   = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [INDEX_BITS-1:0]        point_index,
	input  logic signed [INDEX_BITS:0]   texcoord_index,
	input  logic signed [INDEX_BITS:0]   normal_index,
	input  logic                         face_end,
	input  logic                         new_mesh,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fvd_pkg::VNUM_W-1:0]   vertex_number,
	output logic                         first_use,
	output logic [INDEX_BITS-1:0]        out_point,
	output logic signed [INDEX_BITS:0]   out_texcoord,
	output logic signed [INDEX_BITS:0]   out_normal,
	output logic                         table_full,
	output logic                         run_last
);

	import fvd_pkg::*;

	localparam int KW    = 3 * INDEX_BITS + 2;
	localparam int LIMIT = (MAX_VERTICES < TABLE_SLOTS) ? MAX_VERTICES : TABLE_SLOTS;
	localparam int NB    = $clog2(LIMIT + 1);

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_CLR   = 2'd1;
	localparam logic [1:0] T_START = 2'd2;
	localparam logic [1:0] T_WAIT  = 2'd3;

	logic          use_tex_q;
	logic          use_nrm_q;
	logic [1:0]    st_q;
	logic [1:0]    cnt_q;
	logic [1:0]    idx_q;
	logic [KW-1:0] h0_q;
	logic [KW-1:0] h1_q;
	logic [KW-1:0] k_q [3];
	logic          out_valid_q;

	logic [INDEX_BITS:0] tm;
	logic [INDEX_BITS:0] nm;
	logic [KW-1:0]       cur;
	logic [KW-1:0]       sel_key;
	logic [1:0]          cnt_eff;
	logic                accept;
	logic                take;
	logic                load;

	logic                lk_start;
	logic                lk_clr;
	logic                lk_res_valid;
	logic [NB-1:0]       lk_number;
	lk_flags_t           lk_flags;
	logic                lk_busy;

	assign tm      = use_tex_q ? texcoord_index : '1;
	assign nm      = use_nrm_q ? normal_index : '1;
	assign cur     = {nm, tm, point_index};
	assign cnt_eff = new_mesh ? 2'd0 : cnt_q;

	assign in_stall = (st_q != T_IDLE) || lk_busy;
	assign accept   = in_valid && !in_stall;
	assign take     = !out_valid_q || !out_stall;
	assign load     = (st_q == T_WAIT) && lk_res_valid && take;
	assign lk_start = st_q == T_START;
	assign lk_clr   = accept && new_mesh;
	assign sel_key  = k_q[idx_q];

	fvd_lookup #(
		.MAX_VERTICES(MAX_VERTICES),
		.TABLE_SLOTS (TABLE_SLOTS),
		.INDEX_BITS  (INDEX_BITS)
	) u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr_start (lk_clr),
		.start     (lk_start),
		.key       (sel_key),
		.res_take  (take),
		.res_valid (lk_res_valid),
		.res_number(lk_number),
		.res_flags (lk_flags),
		.busy      (lk_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_tex_q <= 1'b1;
			use_nrm_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_USE_TEX: use_tex_q <= cfg_wdata;
				CFG_USE_NRM: use_nrm_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= T_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			h0_q  <= '0;
			h1_q  <= '0;
		end else begin
			case (st_q)
				T_IDLE: begin
					if (accept) begin
						case (cnt_eff)
							2'd0: begin
								h0_q <= cur;
							end
							2'd1: begin
								h1_q <= cur;
							end
							default: begin
								h1_q  <= cur;
								idx_q <= '0;
							end
						endcase
						if (face_end) begin
							cnt_q <= '0;
						end else begin
							cnt_q <= (cnt_eff == 2'd2) ? 2'd2 : cnt_eff + 2'd1;
						end
						if (new_mesh) begin
							st_q <= T_CLR;
						end else if (cnt_eff == 2'd2) begin
							st_q <= T_START;
						end
					end
				end
				T_CLR: begin
					if (!lk_busy) begin
						st_q <= T_IDLE;
					end
				end
				T_START: begin
					st_q <= T_WAIT;
				end
				T_WAIT: begin
					if (load) begin
						if (idx_q == 2'd2) begin
							st_q <= T_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= T_START;
						end
					end
				end
				default: begin
					st_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == T_IDLE) && accept && !new_mesh && (cnt_q == 2'd2)) begin
			k_q[0] <= h0_q;
			k_q[1] <= h1_q;
			k_q[2] <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			vertex_number <= VNUM_W'(lk_number);
			first_use     <= lk_flags.first_use;
			table_full    <= lk_flags.table_full;
			out_point     <= sel_key[INDEX_BITS-1:0];
			out_texcoord  <= sel_key[INDEX_BITS +: INDEX_BITS + 1];
			out_normal    <= sel_key[2 * INDEX_BITS + 1 +: INDEX_BITS + 1];
			run_last      <= idx_q == 2'd2;
		end
	end

	assign out_valid = out_valid_q;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(first_use && table_full))
		else $error("first_use and table_full both set");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> vertex_number == '0)
		else $error("table_full result carries a nonzero number");

	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == T_IDLE) |-> !lk_res_valid)
		else $error("lookup result while sequencer idle");

endmodule
